FILE: design/rmq_pkg.sv
// Shared widths and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;
  localparam int MatW   = 16;
  localparam int QuatW  = 16;
  localparam int CalcW  = 20;
  localparam int MagW   = 17;
  localparam int SqW    = 2 * MagW;
  localparam int SumW   = SqW + 2;
  localparam int FracSh = 28;
  localparam int RadW   = SumW + FracSh;
  localparam int RootW  = RadW / 2;
  localparam int QW     = 16;
  localparam int NumW   = MagW + FracSh + 2;
  localparam int DivW   = RootW + 1;
  localparam int TrialW = DivW + QW - 1;
  localparam int SideW  = 4 * MagW + 4 + 1;

  localparam logic signed [CalcW-1:0] MatOne  = CalcW'(8192);
  localparam logic [QW-1:0]           QuatOne = QW'(16384);

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;
endpackage

FILE: design/rmq_if.sv
// Matrix input and quaternion output channel interfaces.
interface rmq_in_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  logic signed [MatW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  logic signed [QuatW-1:0] quat_x, quat_y, quat_z, quat_w;
  logic degenerate;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, degenerate, output ready);
endinterface

FILE: design/rotation_matrix_to_unit_quaternion.sv
// Pipeline: 3 front stages, 32 root stages, 16 divide stages and 1 output stage.
// Throughput: one matrix per cycle while the output is not stalled.
// The root and the four divides are unrolled one result bit per stage.
// All stages advance together; a stalled output holds the whole pipeline.
// Reset (asynchronous, active low) clears every stage valid bit.
module rotation_matrix_to_unit_quaternion import rmq_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  rmq_in_if.sink   mat_i,
  rmq_out_if.source quat_o
);
  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || quat_o.ready;
  assign mat_i.ready = en;

  // stage 1: branch select and vector
  logic signed [CalcW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [CalcW-1:0] tr, rad, dmax;
  logic signed [CalcW-1:0] v [4];
  logic [1:0]              sel;
  logic [MagW-1:0]         mag_d [4];
  logic [3:0]              neg_d;

  always_comb begin
    e00 = CalcW'(mat_i.m00); e01 = CalcW'(mat_i.m01); e02 = CalcW'(mat_i.m02);
    e10 = CalcW'(mat_i.m10); e11 = CalcW'(mat_i.m11); e12 = CalcW'(mat_i.m12);
    e20 = CalcW'(mat_i.m20); e21 = CalcW'(mat_i.m21); e22 = CalcW'(mat_i.m22);
    tr   = e00 + e11 + e22;
    sel  = AxisX;
    dmax = e00;
    if (e11 > e00) begin
      sel  = AxisY;
      dmax = e11;
    end
    if (e22 > dmax) sel = AxisZ;
    if (tr > 0) begin
      rad  = tr + MatOne;
      v[0] = e21 - e12;
      v[1] = e02 - e20;
      v[2] = e10 - e01;
      v[3] = rad;
    end else begin
      unique case (sel)
        AxisY: begin
          rad  = e11 - (e22 + e00) + MatOne;
          v[1] = rad;
          v[3] = e02 - e20;
          v[2] = e21 + e12;
          v[0] = e01 + e10;
        end
        AxisZ: begin
          rad  = e22 - (e00 + e11) + MatOne;
          v[2] = rad;
          v[3] = e10 - e01;
          v[0] = e02 + e20;
          v[1] = e12 + e21;
        end
        default: begin
          rad  = e00 - (e11 + e22) + MatOne;
          v[0] = rad;
          v[3] = e21 - e12;
          v[1] = e10 + e01;
          v[2] = e20 + e02;
        end
      endcase
    end
    for (int n = 0; n < 4; n++) begin
      neg_d[n] = v[n][CalcW-1];
      mag_d[n] = neg_d[n] ? MagW'(-v[n]) : MagW'(v[n]);
    end
  end

  logic            s1_vld_q, s2_vld_q, s3_vld_q;
  logic [MagW-1:0] s1_mag_q [4];
  logic [MagW-1:0] s2_mag_q [4];
  logic [MagW-1:0] s3_mag_q [4];
  logic [3:0]      s1_neg_q, s2_neg_q, s3_neg_q;
  logic            s1_dg_q, s2_dg_q, s3_dg_q;
  logic [SqW-1:0]  s2_sq_q [4];
  logic [SumW-1:0] s3_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= mat_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mag_q <= mag_d;
      s1_neg_q <= neg_d;
      s1_dg_q  <= (rad <= 0);
      for (int n = 0; n < 4; n++) s2_sq_q[n] <= SqW'(s1_mag_q[n]) * SqW'(s1_mag_q[n]);
      s2_mag_q <= s1_mag_q;
      s2_neg_q <= s1_neg_q;
      s2_dg_q  <= s1_dg_q;
      s3_sum_q <= SumW'(s2_sq_q[0]) + SumW'(s2_sq_q[1]) + SumW'(s2_sq_q[2])
                + SumW'(s2_sq_q[3]);
      s3_mag_q <= s2_mag_q;
      s3_neg_q <= s2_neg_q;
      s3_dg_q  <= s2_dg_q;
    end
  end

  // square root of the length squared scaled by 2^28
  logic             sq_vld;
  logic [RootW-1:0] len;
  logic [SideW-1:0] sq_side;

  rmq_isqrt #(
    .RtW (RootW),
    .SdW (SideW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   ({s3_sum_q, {FracSh{1'b0}}}),
    .side_i  ({s3_mag_q[3], s3_mag_q[2], s3_mag_q[1], s3_mag_q[0], s3_neg_q, s3_dg_q}),
    .valid_o (sq_vld),
    .root_o  (len),
    .side_o  (sq_side)
  );

  // restoring divides, one quotient bit per stage, four lanes
  logic [NumW-1:0] drem_w [QW+1][4];
  logic [QW-1:0]   dq_w   [QW+1][4];
  logic [DivW-1:0] ddv_w  [QW+1];
  logic [3:0]      dneg_w [QW+1];
  logic            ddg_w  [QW+1];
  logic            dvld_w [QW+1];

  for (genvar n = 0; n < 4; n++) begin : g_div_in
    assign drem_w[0][n] = (NumW'(sq_side[5 + n*MagW +: MagW]) << (FracSh + 1)) + NumW'(len);
    assign dq_w[0][n]   = '0;
  end
  assign ddv_w[0]  = {len, 1'b0};
  assign dneg_w[0] = sq_side[4:1];
  assign ddg_w[0]  = sq_side[0];
  assign dvld_w[0] = sq_vld;

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int B = QW - 1 - s;
    logic [NumW-1:0] rem_d [4];
    logic [NumW-1:0] rem_q [4];
    logic [QW-1:0]   q_d   [4];
    logic [QW-1:0]   q_q   [4];
    logic [DivW-1:0] dv_q;
    logic [3:0]      neg_q;
    logic            dg_q;
    logic            vld_q;
    logic [TrialW-1:0] trial;

    always_comb begin
      trial = TrialW'(ddv_w[s]) << B;
      for (int n = 0; n < 4; n++) begin
        rem_d[n] = drem_w[s][n];
        q_d[n]   = dq_w[s][n];
        if (TrialW'(drem_w[s][n]) >= trial) begin
          rem_d[n] = NumW'(TrialW'(drem_w[s][n]) - trial);
          q_d[n]   = dq_w[s][n] | (QW'(1) << B);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= dvld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q <= rem_d;
        q_q   <= q_d;
        dv_q  <= ddv_w[s];
        neg_q <= dneg_w[s];
        dg_q  <= ddg_w[s];
      end
    end

    assign drem_w[s+1] = rem_q;
    assign dq_w[s+1]   = q_q;
    assign ddv_w[s+1]  = dv_q;
    assign dneg_w[s+1] = neg_q;
    assign ddg_w[s+1]  = dg_q;
    assign dvld_w[s+1] = vld_q;
  end

  // output register: saturate, sign, identity on degenerate
  logic [QuatW-1:0] res_d [4];
  logic [QuatW-1:0] res_q [4];
  logic             dg_out_q;
  logic [QW-1:0]    sat;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      sat      = (dq_w[QW][n] > QuatOne) ? QuatOne : dq_w[QW][n];
      res_d[n] = dneg_w[QW][n] ? QuatW'(-sat) : QuatW'(sat);
      if (ddg_w[QW]) res_d[n] = (n == 3) ? QuatW'(QuatOne) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dvld_w[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q    <= res_d;
      dg_out_q <= ddg_w[QW];
    end
  end

  assign quat_o.valid      = out_vld_q;
  assign quat_o.quat_x     = res_q[0];
  assign quat_o.quat_y     = res_q[1];
  assign quat_o.quat_z     = res_q[2];
  assign quat_o.quat_w     = res_q[3];
  assign quat_o.degenerate = dg_out_q;

`ifndef ASSERT_OFF
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quat_o.valid && quat_o.degenerate |->
      quat_o.quat_x == 0 && quat_o.quat_y == 0 && quat_o.quat_z == 0
      && quat_o.quat_w == QuatW'(QuatOne))
    else $error("degenerate result is not the identity");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quat_o.valid |-> quat_o.quat_w <= $signed(QuatW'(QuatOne))
      && quat_o.quat_w >= -$signed(QuatW'(QuatOne)))
    else $error("scalar component out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quat_o.valid && !quat_o.ready |=> quat_o.valid && $stable(quat_o.quat_x)
      && $stable(quat_o.degenerate) && !$past(mat_i.ready))
    else $error("stall did not freeze the pipeline");
`endif
endmodule

FILE: design/rmq_isqrt.sv
// Bit-per-stage pipelined integer square root with sideband payload.
module rmq_isqrt import rmq_pkg::*; #(
  parameter int RtW = RootW,
  parameter int SdW = SideW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*RtW-1:0] rad_i,
  input  logic [SdW-1:0]   side_i,
  output logic             valid_o,
  output logic [RtW-1:0]   root_o,
  output logic [SdW-1:0]   side_o
);
  logic [2*RtW-1:0] rem_w  [RtW+1];
  logic [RtW-1:0]   root_w [RtW+1];
  logic [SdW-1:0]   side_w [RtW+1];
  logic             vld_w  [RtW+1];

  assign rem_w[0]  = rad_i;
  assign root_w[0] = '0;
  assign side_w[0] = side_i;
  assign vld_w[0]  = valid_i;

  for (genvar s = 0; s < RtW; s++) begin : g_stage
    localparam int B = RtW - 1 - s;
    logic [2*RtW-1:0] trial;
    logic [2*RtW-1:0] rem_d, rem_q;
    logic [RtW-1:0]   root_d, root_q;
    logic [SdW-1:0]   side_q;
    logic             vld_q;

    always_comb begin
      trial  = ({{RtW{1'b0}}, root_w[s]} << (B + 1)) | ((2*RtW)'(1) << (2 * B));
      rem_d  = rem_w[s];
      root_d = root_w[s];
      if (rem_w[s] >= trial) begin
        rem_d  = rem_w[s] - trial;
        root_d = root_w[s] | (RtW'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        side_q <= side_w[s];
      end
    end

    assign rem_w[s+1]  = rem_q;
    assign root_w[s+1] = root_q;
    assign side_w[s+1] = side_q;
    assign vld_w[s+1]  = vld_q;
  end

  assign valid_o = vld_w[RtW];
  assign root_o  = root_w[RtW];
  assign side_o  = side_w[RtW];
endmodule
